[rtl/top_k_nearest_vote_top_macros.svh]
// Assertion macros for the top-k nearest vote RTL.
// Used by the top level to check its own logic; no other dependencies.
`ifndef TOP_K_NEAREST_VOTE_TOP_MACROS_SVH
`define TOP_K_NEAREST_VOTE_TOP_MACROS_SVH

// Same-cycle implication.
`define TKNV_ASSERT_IMP(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define TKNV_ASSERT_NXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/tknv_pkg.sv]
// Package for the top-k nearest vote block: field widths, word types,
// slot type, control structs and the sequencer state enum. No dependencies.
`default_nettype none

package tknv_pkg;

   localparam int TOP_K_DEFAULT       = 50;
   localparam int CLASS_COUNT_DEFAULT = 10;

   localparam int DIST_WIDTH   = 16;
   localparam int INDEX_WIDTH  = 16;
   localparam int LABEL_WIDTH  = 4;
   localparam int CSR_WIDTH    = 6;
   localparam int FILLED_WIDTH = 6;

   localparam logic [CSR_WIDTH-1:0]    VOTE_COUNT_RESET = CSR_WIDTH'(7);
   localparam logic [FILLED_WIDTH-1:0] FILLED_MAX       = '1;

   // Input word
   typedef struct packed {
      logic [DIST_WIDTH-1:0]  distance;
      logic [INDEX_WIDTH-1:0] item_index;
      logic [LABEL_WIDTH-1:0] item_label;
      logic [LABEL_WIDTH-1:0] true_label;
      logic                   last;
   } req_type;

   // Result word
   typedef struct packed {
      logic [INDEX_WIDTH-1:0]  nearest_index;
      logic [LABEL_WIDTH-1:0]  nearest_label;
      logic [DIST_WIDTH-1:0]   nearest_distance;
      logic [LABEL_WIDTH-1:0]  vote_label;
      logic [FILLED_WIDTH-1:0] filled;
      logic                    truth_in_top_k;
      logic                    top1_hit;
      logic                    vote_hit;
   } rsp_type;

   // One list entry
   typedef struct packed {
      logic                   valid;
      logic [DIST_WIDTH-1:0]  distance;
      logic [INDEX_WIDTH-1:0] index;
      logic [LABEL_WIDTH-1:0] label;
   } slot_type;

   localparam slot_type SLOT_RESET = '{
      valid:    1'b0,
      distance: '1,
      index:    '0,
      label:    '0
   };

   // Cell control: insert a candidate or shift toward the head
   typedef struct packed {
      logic insert;
      logic shift;
   } tknv_cell_ctl_type;

   // Tally control from the sequencer
   typedef struct packed {
      logic start;
      logic scan;
      logic vote;
   } tknv_ctl_type;

   // Tally status back to the sequencer
   typedef struct packed {
      logic drain_done;
      logic vote_done;
   } tknv_status_type;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_DRAIN,
      ST_VOTE,
      ST_PUBLISH
   } state_type;

endpackage

`default_nettype wire

[rtl/tknv_cell.sv]
// One slot of the sorted top-k list. Takes the candidate, its left
// neighbor's entry, or its right neighbor's entry. Depends on tknv_pkg.
`default_nettype none

module tknv_cell import tknv_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   input  tknv_cell_ctl_type ctl,
   input  slot_type          cand,
   input  slot_type          prev_slot,
   input  wire               prev_take,
   input  slot_type          next_slot,
   output slot_type          slot,
   output logic              take
);

   slot_type slot_ff;
   slot_type slot_in;

   // Candidate belongs here or earlier: free slot or strictly closer
   assign take = !slot_ff.valid || (cand.distance < slot_ff.distance);

   // Next entry
   always_comb begin
      slot_in = slot_ff;
      if (ctl.shift) begin
         slot_in = next_slot;
      end else if (ctl.insert) begin
         if (prev_take) begin
            slot_in = prev_slot;
         end else if (take) begin
            slot_in = cand;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_RESET;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

`default_nettype wire

[rtl/tknv_tally.sv]
// Scans the list as it drains out of the head cell, counts votes, fill and
// truth matches, then picks the winning class one class a cycle. Uses tknv_pkg.
`default_nettype none

module tknv_tally import tknv_pkg::*; #(
   parameter int TOP_K       = TOP_K_DEFAULT,
   parameter int CLASS_COUNT = CLASS_COUNT_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  tknv_ctl_type          ctl,
   input  slot_type              head,
   input  wire [LABEL_WIDTH-1:0] truth,
   input  wire [CSR_WIDTH-1:0]   vote_count,
   output tknv_status_type       status,
   output rsp_type               result
);

   localparam int PosWidth = (TOP_K > 1) ? $clog2(TOP_K) : 1;
   localparam int CntWidth = $clog2(TOP_K + 1);
   localparam int ClsWidth = $clog2(CLASS_COUNT);
   localparam int CmpWidth = (PosWidth > CSR_WIDTH) ? PosWidth : CSR_WIDTH;
   localparam int SatWidth = (CntWidth > FILLED_WIDTH) ? CntWidth : FILLED_WIDTH;

   logic [PosWidth-1:0]    pos_ff, pos_in;
   logic [ClsWidth-1:0]    cls_ff, cls_in;
   logic [CntWidth-1:0]    count_ff [CLASS_COUNT];
   logic [CntWidth-1:0]    fill_ff, fill_in;
   logic [CntWidth-1:0]    best_cnt_ff, best_cnt_in;
   logic [LABEL_WIDTH-1:0] best_ff, best_in;
   logic [LABEL_WIDTH-1:0] truth_ff;
   logic                   cast_ff, cast_in;
   logic                   truth_in_ff, truth_in_in;
   logic                   top1_ff, top1_in;
   slot_type               nearest_ff;
   logic                   in_vote;
   logic                   head_match;
   logic [SatWidth-1:0]    fill_ext;

   // Head entry lies in the voting window and carries a class that votes
   assign in_vote    = head.valid && (CmpWidth'(pos_ff) < CmpWidth'(vote_count))
                       && ({1'b0, head.label} < (LABEL_WIDTH + 1)'(CLASS_COUNT));
   assign head_match = head.valid && (head.label == truth_ff);

   assign status.drain_done = ctl.scan && (pos_ff == PosWidth'(TOP_K - 1));
   assign status.vote_done  = ctl.vote && (cls_ff == ClsWidth'(CLASS_COUNT - 1));

   // Scan and argmax bookkeeping
   always_comb begin
      pos_in      = pos_ff;
      cls_in      = cls_ff;
      fill_in     = fill_ff;
      cast_in     = cast_ff;
      truth_in_in = truth_in_ff;
      top1_in     = top1_ff;
      best_in     = best_ff;
      best_cnt_in = best_cnt_ff;
      if (ctl.start) begin
         pos_in      = '0;
         cls_in      = '0;
         fill_in     = '0;
         cast_in     = 1'b0;
         truth_in_in = 1'b0;
         top1_in     = 1'b0;
         best_in     = '0;
         best_cnt_in = '0;
      end else if (ctl.scan) begin
         pos_in = pos_ff + PosWidth'(1);
         if (head.valid) begin
            fill_in = fill_ff + CntWidth'(1);
         end
         if (in_vote) begin
            cast_in = 1'b1;
         end
         if (head_match) begin
            truth_in_in = 1'b1;
         end
         if (pos_ff == '0) begin
            top1_in = head_match;
         end
      end else if (ctl.vote) begin
         cls_in = cls_ff + ClsWidth'(1);
         // strict compare keeps the lowest class on a tie
         if (count_ff[cls_ff] > best_cnt_ff) begin
            best_in     = LABEL_WIDTH'(cls_ff);
            best_cnt_in = count_ff[cls_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         cls_ff      <= '0;
         fill_ff     <= '0;
         cast_ff     <= 1'b0;
         truth_in_ff <= 1'b0;
         top1_ff     <= 1'b0;
         best_ff     <= '0;
         best_cnt_ff <= '0;
      end else begin
         pos_ff      <= pos_in;
         cls_ff      <= cls_in;
         fill_ff     <= fill_in;
         cast_ff     <= cast_in;
         truth_in_ff <= truth_in_in;
         top1_ff     <= top1_in;
         best_ff     <= best_in;
         best_cnt_ff <= best_cnt_in;
      end
   end

   // Per-class vote counters, each bumped by its own label decode
   for (genvar c = 0; c < CLASS_COUNT; c++) begin : g_count
      always_ff @(posedge clock) begin
         if (reset || ctl.start) begin
            count_ff[c] <= '0;
         end else if (ctl.scan && in_vote && (head.label == LABEL_WIDTH'(c))) begin
            count_ff[c] <= count_ff[c] + CntWidth'(1);
         end
      end
   end

   // Query label and nearest entry captures
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         truth_ff <= truth;
      end
      if (ctl.scan && (pos_ff == '0)) begin
         nearest_ff <= head;
      end
   end

   assign fill_ext = SatWidth'(fill_ff);

   // Result word
   always_comb begin
      result.nearest_index    = nearest_ff.index;
      result.nearest_label    = nearest_ff.label;
      result.nearest_distance = nearest_ff.distance;
      result.vote_label       = best_ff;
      result.filled           = (fill_ext > SatWidth'(FILLED_MAX)) ? FILLED_MAX
                                : fill_ext[FILLED_WIDTH-1:0];
      result.truth_in_top_k   = truth_in_ff;
      result.top1_hit         = top1_ff;
      result.vote_hit         = cast_ff && (best_ff == truth_ff);
   end

endmodule

`default_nettype wire

[rtl/top_k_nearest_vote_top.sv]
// Top level of the top-k nearest vote block: cell chain, sequencer,
// vote_count register and result register. Uses tknv_pkg, tknv_cell, tknv_tally.
//
//   channel  ports                              direction
//   req      req_valid/req_ready/req_data       in, one candidate word
//   rsp      rsp_valid/rsp_ready/rsp_data       out, one result word per query
//   csr      csr_write_en/csr_write_data        in, vote_count write
//
// A candidate word is taken every cycle while the sequencer collects; the chain
// registers it into its sorted place as it is accepted. After a word with last
// set, no word is taken until the list is shifted out through the tally, the
// classes are compared one at a time to pick the winner, and the result register is loaded.
// The load waits while an earlier result is still held on rsp.
// Reset empties the list and sets vote_count to 7.
`default_nettype none
`include "top_k_nearest_vote_top_macros.svh"

module top_k_nearest_vote_top import tknv_pkg::*; #(
   parameter int TOP_K       = TOP_K_DEFAULT,
   parameter int CLASS_COUNT = CLASS_COUNT_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output rsp_type             rsp_data,
   input  wire                 csr_write_en,
   input  wire [CSR_WIDTH-1:0] csr_write_data
);

   state_type            state_ff, state_in;
   logic [CSR_WIDTH-1:0] vote_count_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;
   logic                 req_accept;
   logic                 load;
   tknv_ctl_type         ctl;
   tknv_cell_ctl_type    cell_ctl;
   tknv_status_type      status;
   rsp_type              result;
   slot_type             cand;
   slot_type             slots [TOP_K];
   logic                 takes [TOP_K];

   assign req_accept = req_valid && req_ready;

   // Candidate entry
   assign cand = '{
      valid:    1'b1,
      distance: req_data.distance,
      index:    req_data.item_index,
      label:    req_data.item_label
   };

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      load      = 1'b0;
      ctl       = '0;
      case (state_ff)
         ST_COLLECT: begin
            req_ready = 1'b1;
            if (req_accept && req_data.last) begin
               ctl.start = 1'b1;
               state_in  = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            ctl.scan = 1'b1;
            if (status.drain_done) begin
               state_in = ST_VOTE;
            end
         end
         ST_VOTE: begin
            ctl.vote = 1'b1;
            if (status.vote_done) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cell_ctl.insert = req_accept;
   assign cell_ctl.shift  = ctl.scan;

   // Cell chain, slot 0 is the nearest
   for (genvar i = 0; i < TOP_K; i++) begin : g_cell
      slot_type prev_slot;
      slot_type next_slot;
      logic     prev_take;

      if (i == 0) begin : g_head
         assign prev_slot = SLOT_RESET;
         assign prev_take = 1'b0;
      end else begin : g_body
         assign prev_slot = slots[i-1];
         assign prev_take = takes[i-1];
      end

      if (i == TOP_K - 1) begin : g_tail
         assign next_slot = SLOT_RESET;
      end else begin : g_link
         assign next_slot = slots[i+1];
      end

      tknv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .cand      (cand),
         .prev_slot (prev_slot),
         .prev_take (prev_take),
         .next_slot (next_slot),
         .slot      (slots[i]),
         .take      (takes[i])
      );
   end

   tknv_tally #(
      .TOP_K       (TOP_K),
      .CLASS_COUNT (CLASS_COUNT)
   ) u_tally (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .head       (slots[0]),
      .truth      (req_data.true_label),
      .vote_count (vote_count_ff),
      .status     (status),
      .result     (result)
   );

   // vote_count register
   always_ff @(posedge clock) begin
      if (reset) begin
         vote_count_ff <= VOTE_COUNT_RESET;
      end else if (csr_write_en) begin
         vote_count_ff <= csr_write_data;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   for (genvar j = 1; j < TOP_K; j++) begin : g_chk
      `TKNV_ASSERT_IMP(a_sorted, clock, reset, slots[j].valid, slots[j-1].valid && (slots[j-1].distance <= slots[j].distance), "list out of order")
   end

   `TKNV_ASSERT_NXT(a_empty_after_drain, clock, reset, status.drain_done, !slots[0].valid, "list not empty after drain")

   `TKNV_ASSERT_NXT(a_publish, clock, reset, (state_ff == ST_PUBLISH) && !rsp_valid_ff, rsp_valid_ff && (state_ff == ST_COLLECT), "result not loaded")

endmodule

`default_nettype wire

[bench/nearest_vote_checker.sv]
// Checker for the top-k nearest vote block: follows vote_count writes, keeps its own
// sorted list of candidate words, predicts each query result and compares it.
// Depends on tknv_pkg only.

module nearest_vote_checker import tknv_pkg::*; #(
   parameter int TOP_K       = TOP_K_DEFAULT,
   parameter int CLASS_COUNT = CLASS_COUNT_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_WIDTH-1:0] csr_write_data,
   output int                   error_count,
   output int                   results_pending
);

   slot_type             kept [TOP_K];
   logic [CSR_WIDTH-1:0] vote_setting;
   rsp_type              result_q [$];

   initial begin
      error_count     = 0;
      results_pending = 0;
   end

   // Empty list: every slot back to its reset value
   function automatic void clear_kept();
      int i;
      for (i = 0; i < TOP_K; i++)
         kept[i] = SLOT_RESET;
   endfunction

   // Sorted insert; a full list only takes a strictly closer candidate,
   // and equal distances keep the older entry in front
   function automatic void place_candidate(input req_type w);
      int p;
      p = TOP_K - 1;
      if (kept[p].valid && w.distance >= kept[p].distance)
         return;
      while (p > 0 && (!kept[p-1].valid || w.distance < kept[p-1].distance)) begin
         kept[p] = kept[p-1];
         p--;
      end
      kept[p].valid    = 1'b1;
      kept[p].distance = w.distance;
      kept[p].index    = w.item_index;
      kept[p].label    = w.item_label;
   endfunction

   // Result of the current list: nearest entry, vote over the leading slots,
   // hit flags. Free slots and out-of-range labels cast no vote.
   function automatic rsp_type tally_query(input logic [LABEL_WIDTH-1:0] truth);
      int      tally [CLASS_COUNT];
      int      i;
      int      used;
      int      cast;
      int      best;
      int      voters;
      bit      truth_seen;
      rsp_type r;
      for (i = 0; i < CLASS_COUNT; i++)
         tally[i] = 0;
      used       = 0;
      cast       = 0;
      best       = 0;
      truth_seen = 1'b0;
      voters     = (vote_setting > TOP_K) ? TOP_K : int'(vote_setting);
      for (i = 0; i < TOP_K; i++) begin
         if (kept[i].valid) begin
            used++;
            if (kept[i].label == truth)
               truth_seen = 1'b1;
            if (i < voters && kept[i].label < CLASS_COUNT) begin
               tally[kept[i].label]++;
               cast++;
            end
         end
      end
      // strict compare: the lowest class keeps a tie
      for (i = 1; i < CLASS_COUNT; i++)
         if (tally[i] > tally[best])
            best = i;
      r.nearest_index    = kept[0].index;
      r.nearest_label    = kept[0].label;
      r.nearest_distance = kept[0].distance;
      r.vote_label       = LABEL_WIDTH'(best);
      r.filled           = (used > int'(FILLED_MAX)) ? FILLED_MAX : FILLED_WIDTH'(used);
      r.truth_in_top_k   = truth_seen;
      r.top1_hit         = kept[0].valid && kept[0].label == truth;
      r.vote_hit         = cast > 0 && best == int'(truth);
      return r;
   endfunction

   function automatic int field_diff(input string name, input int unsigned want,
                                     input int unsigned got);
      if (want == got)
         return 0;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1;
   endfunction

   function automatic int compare_result(input rsp_type want, input rsp_type got);
      int bad;
      bad = 0;
      bad += field_diff("nearest_index", want.nearest_index, got.nearest_index);
      bad += field_diff("nearest_label", want.nearest_label, got.nearest_label);
      bad += field_diff("nearest_distance", want.nearest_distance, got.nearest_distance);
      bad += field_diff("vote_label", want.vote_label, got.vote_label);
      bad += field_diff("filled", want.filled, got.filled);
      bad += field_diff("truth_in_top_k", want.truth_in_top_k, got.truth_in_top_k);
      bad += field_diff("top1_hit", want.top1_hit, got.top1_hit);
      bad += field_diff("vote_hit", want.vote_hit, got.vote_hit);
      return bad;
   endfunction

   // Watch all three ports at the rising edge
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         clear_kept();
         vote_setting = VOTE_COUNT_RESET;
         result_q.delete();
      end else begin
         // result first, so a word and a result on the same edge stay in order
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               $display("%0t: result word with none expected, got %h", $time, rsp_data);
               error_count++;
            end else begin
               want = result_q.pop_front();
               error_count += compare_result(want, rsp_data);
            end
         end
         if (csr_write_en)
            vote_setting = csr_write_data;
         if (req_valid && req_ready) begin
            place_candidate(req_data);
            if (req_data.last) begin
               result_q.push_back(tally_query(req_data.true_label));
               clear_kept();
            end
         end
      end
      results_pending = result_q.size();
   end

endmodule

[bench/testbench.sv]
// Top of the top-k nearest vote bench: clock, reset, candidate and result traffic,
// vote_count writes and the verdict. Uses tknv_pkg, nearest_vote_checker and the block.

module testbench;
   import tknv_pkg::*;

   localparam int SETTLE_CYCLES  = TOP_K_DEFAULT + CLASS_COUNT_DEFAULT + 8;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int PHASE_WORDS    = 42;
   localparam int PHASE_QUERIES  = 3;
   localparam int HOLD_CYCLES    = 600;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_write_en;
   logic [CSR_WIDTH-1:0] csr_write_data;
   int                   error_count;
   int                   results_pending;

   int words_sent;
   int queries_sent;
   int burst_left;
   bit pacing;
   bit hold_request;

   top_k_nearest_vote_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   nearest_vote_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // Result side: random ready patterns, plus one long hold-off on request
   initial begin : rsp_side
      int  mode;
      int  mode_left;
      bit  hold_done;
      mode      = 0;
      mode_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Drop valid and leave the request side idle
   task automatic idle_for(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Offer one word and hold it until taken; bursts with random gaps when pacing
   task automatic send_word(input req_type w);
      if (burst_left == 0) begin
         if (pacing && $urandom_range(0, 3) != 0)
            idle_for($urandom_range(1, 8));
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (w.last)
         queries_sent++;
   endtask

   task automatic send_item(input int d, input int idx, input int lab, input int truth,
                            input bit last);
      req_type w;
      w.distance   = DIST_WIDTH'(d);
      w.item_index = INDEX_WIDTH'(idx);
      w.item_label = LABEL_WIDTH'(lab);
      w.true_label = LABEL_WIDTH'(truth);
      w.last       = last;
      send_word(w);
   endtask

   // Mostly real classes, now and then one of the unused label codes
   function automatic logic [LABEL_WIDTH-1:0] pick_label();
      if ($urandom_range(0, 99) < 85)
         return LABEL_WIDTH'($urandom_range(0, CLASS_COUNT_DEFAULT - 1));
      return LABEL_WIDTH'($urandom_range(CLASS_COUNT_DEFAULT, 15));
   endfunction

   // One query: mostly short, some medium, a few that overflow the list
   task automatic send_query();
      int                     len;
      int                     dist_top;
      int                     sel;
      int                     n;
      logic [LABEL_WIDTH-1:0] truth;
      req_type                w;
      sel = $urandom_range(0, 99);
      if (sel < 80)
         len = $urandom_range(1, 12);
      else if (sel < 95)
         len = $urandom_range(13, 45);
      else
         len = $urandom_range(TOP_K_DEFAULT + 1, TOP_K_DEFAULT + 25);
      // narrow distance ranges give plenty of ties
      case ($urandom_range(0, 2))
         0: dist_top = 15;
         1: dist_top = 255;
         default: dist_top = 65535;
      endcase
      truth = pick_label();
      for (n = 1; n <= len; n++) begin
         w.distance   = DIST_WIDTH'($urandom_range(0, dist_top));
         w.item_index = INDEX_WIDTH'($urandom);
         w.item_label = pick_label();
         w.true_label = (n == len) ? truth : LABEL_WIDTH'($urandom_range(0, 15));
         w.last       = (n == len);
         send_word(w);
      end
   endtask

   // Wait until every result is in and the block has gone quiet
   task automatic settle();
      idle_for(1);
      wait (results_pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vote(input logic [CSR_WIDTH-1:0] v);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CSR_WIDTH-1:0] settings [8];
      int                   phase;
      int                   word_goal;
      int                   query_goal;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      words_sent     = 0;
      queries_sent   = 0;
      burst_left     = 0;
      pacing         = 1'b0;
      hold_request   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed queries at the reset vote_count
      // single word, all fields at zero
      send_item(0, 0, 0, 0, 1'b1);
      // single word, all fields at their top, label that cannot vote
      send_item(65535, 65535, 15, 15, 1'b1);
      // equal distances: arrival order kept, majority of class 4
      send_item(100, 1, 3, 0, 1'b0);
      send_item(100, 2, 4, 0, 1'b0);
      send_item(100, 3, 5, 0, 1'b0);
      send_item(100, 4, 4, 4, 1'b1);
      // vote tie between classes 9 and 2: the lower class wins
      send_item(5, 10, 9, 0, 1'b0);
      send_item(6, 11, 2, 9, 1'b1);
      // falling distances push every entry back
      send_item(40, 20, 1, 0, 1'b0);
      send_item(30, 21, 1, 0, 1'b0);
      send_item(20, 22, 6, 0, 1'b0);
      send_item(10, 23, 6, 6, 1'b1);
      // nearest entry has a non-voting label that matches the true label
      send_item(1, 30, 10, 0, 1'b0);
      send_item(2, 31, 3, 10, 1'b1);
      settle();

      // Random phases, one vote_count setting each
      settings = '{6'd0, 6'd63, 6'd1, 6'd50, CSR_WIDTH'($urandom_range(2, 49)), 6'd51,
                   6'd7, CSR_WIDTH'($urandom_range(0, 63))};
      pacing = 1'b1;
      for (phase = 0; phase < 8; phase++) begin
         write_vote(settings[phase]);
         if (phase == 2)
            hold_request = 1'b1;
         word_goal  = words_sent + PHASE_WORDS;
         query_goal = queries_sent + PHASE_QUERIES;
         while (words_sent < word_goal || queries_sent < query_goal)
            send_query();
         settle();
      end

      if (error_count == 0 && results_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
